[sv/sorted_event_list_assert.svh]
// Assertion helpers for the sorted event list.
`ifndef SORTED_EVENT_LIST_ASSERT_SVH
`define SORTED_EVENT_LIST_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SEL_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sorted_event_list assertion failed");

// next-cycle implication, disabled in reset
`define SEL_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sorted_event_list assertion failed");

`endif

[sv/sel_pkg.sv]
`default_nettype none
package sel_pkg;
  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REWIND = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_END     = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  localparam logic [1:0] MODE_POS = 2'd0;
  localparam logic [1:0] MODE_DUR = 2'd1;
  localparam logic [1:0] MODE_REL = 2'd2;

  // record word order: position, duration, release, payload (low to high)
  function automatic logic [31:0] key_sel(input logic [127:0] r, input logic [1:0] m);
    logic [31:0] k;
    case (m)
      MODE_POS: k = r[31:0];
      MODE_DUR: k = r[63:32];
      MODE_REL: k = r[95:64];
      default:  k = 32'd0;
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

[sv/sel_ifs.sv]
`default_nettype none
interface sel_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] note_position;
  logic [31:0] note_duration;
  logic [31:0] release_time;
  logic [31:0] payload;
  modport source (output valid, command, note_position, note_duration, release_time,
                  payload, input ready);
  modport sink (input valid, command, note_position, note_duration, release_time,
                payload, output ready);
endinterface

interface sel_res_if #(parameter int CW = 7);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [31:0]   out_position;
  logic [31:0]   out_duration;
  logic [31:0]   out_release;
  logic [31:0]   out_payload;
  logic [CW-1:0] entry_count;
  modport source (output valid, status, out_position, out_duration, out_release,
                  out_payload, entry_count, input ready);
  modport sink (input valid, status, out_position, out_duration, out_release,
                out_payload, entry_count, output ready);
endinterface

interface sel_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] sort_mode;
  modport source (output valid, sort_mode, input ready);
  modport sink (input valid, sort_mode, output ready);
endinterface
`default_nettype wire

[sv/sorted_event_list.sv]
// Commands are taken one at a time; an insert walks the records in the list, and a
// held result beat stalls the next command.
// Reset (rst, synchronous): list empty, cursor past the end, sort_mode position.
// Free slots come from a fill counter plus a released-slot chain, so no clearing pass.
`default_nettype none
module sorted_event_list #(
  parameter int DEPTH     = sel_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = sel_pkg::KEY_WIDTH_DEF,
  parameter int LW        = $clog2(DEPTH + 1)
) (
  input  wire           clk,
  input  wire           rst,
  sel_cmd_if.sink       cmd,
  sel_res_if.source     res,
  sel_cfg_if.sink       cfg
);
  localparam int AW = $clog2(DEPTH);
  localparam int KB = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam logic [31:0] KMASK = 32'((64'd1 << KB) - 64'd1);
  localparam logic [LW-1:0] NONE = LW'(DEPTH);
  localparam logic [LW-1:0] ONE  = LW'(1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_FREE = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_WALK_RD  = 4'd3;
  localparam logic [3:0] S_WALK_CMP = 4'd4;
  localparam logic [3:0] S_LINK1    = 4'd5;
  localparam logic [3:0] S_LINK2    = 4'd6;
  localparam logic [3:0] S_RD_DATA  = 4'd7;
  localparam logic [3:0] S_POP_DATA = 4'd8;
  localparam logic [3:0] S_REL      = 4'd9;
  localparam logic [3:0] S_RMT_DATA = 4'd10;
  localparam logic [3:0] S_RMC_PRV  = 4'd11;
  localparam logic [3:0] S_RMC_DATA = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [127:0]  rec_mem [DEPTH];
  logic [LW-1:0] nxt_mem [DEPTH];
  logic [LW-1:0] prv_mem [DEPTH];
  logic [127:0]  rec_q;
  logic [LW-1:0] nxt_q;
  logic [LW-1:0] prv_q;
  logic [LW-1:0] rd_link;

  logic [3:0]    state;
  logic [1:0]    sort_mode;
  logic [127:0]  rec_in;
  logic [31:0]   key_new;
  logic [LW-1:0] n, p, c, rem;
  logic [LW-1:0] free_head, fill, head, tail, cursor, count;
  logic [2:0]    w_status;
  logic [127:0]  w_rec;
  logic          res_valid;
  logic [2:0]    res_status;
  logic [127:0]  res_rec;
  logic [LW-1:0] res_count;
  logic          cmd_fire;
  logic [127:0]  cmd_rec;
  logic [31:0]   walk_key;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign cmd_rec   = {cmd.payload, cmd.release_time, cmd.note_duration, cmd.note_position};
  assign walk_key  = sel_pkg::key_sel(rec_q, sort_mode) & KMASK;

  assign res.valid        = res_valid;
  assign res.status       = res_status;
  assign res.out_position = res_rec[31:0];
  assign res.out_duration = res_rec[63:32];
  assign res.out_release  = res_rec[95:64];
  assign res.out_payload  = res_rec[127:96];
  assign res.entry_count  = res_count;

  // one shared read address for the three memories
  always_comb begin
    rd_link = free_head;
    case (state)
      S_IDLE: begin
        case (cmd.command)
          sel_pkg::CMD_INSERT: rd_link = free_head;
          sel_pkg::CMD_READ:   rd_link = cursor;
          sel_pkg::CMD_POP:    rd_link = head;
          sel_pkg::CMD_REMOVE: rd_link = (cursor == NONE) ? tail : cursor;
          default:             rd_link = head;
        endcase
      end
      S_WALK_RD: rd_link = c;
      S_RMC_PRV: rd_link = prv_q;
      default:   rd_link = c;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_q <= rec_mem[rd_link[AW-1:0]];
    nxt_q <= nxt_mem[rd_link[AW-1:0]];
    prv_q <= prv_mem[rd_link[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sort_mode <= sel_pkg::MODE_POS;
      free_head <= NONE;
      fill      <= '0;
      head      <= NONE;
      tail      <= NONE;
      cursor    <= NONE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) sort_mode <= cfg.sort_mode;
      // in S_DONE the beat is either held or replaced below
      if (res_valid && res.ready && state != S_DONE) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            rec_in  <= cmd_rec;
            key_new <= sel_pkg::key_sel(cmd_rec, sort_mode) & KMASK;
            w_rec   <= '0;
            case (cmd.command)
              sel_pkg::CMD_INSERT: begin
                if (count == NONE) begin
                  w_status <= sel_pkg::ST_FULL;
                  state    <= S_DONE;
                end else if (free_head != NONE) begin
                  w_status <= sel_pkg::ST_OK;
                  n        <= free_head;
                  state    <= S_INS_FREE;
                end else begin
                  w_status <= sel_pkg::ST_OK;
                  n        <= fill;
                  fill     <= fill + ONE;
                  state    <= S_INS_WR;
                end
              end
              sel_pkg::CMD_REWIND: begin
                cursor   <= head;
                w_status <= sel_pkg::ST_OK;
                state    <= S_DONE;
              end
              sel_pkg::CMD_READ: begin
                if (count == '0 || head == NONE) begin
                  w_status <= sel_pkg::ST_EMPTY;
                  state    <= S_DONE;
                end else if (cursor == NONE) begin
                  w_status <= sel_pkg::ST_END;
                  state    <= S_DONE;
                end else begin
                  w_status <= sel_pkg::ST_OK;
                  state    <= S_RD_DATA;
                end
              end
              sel_pkg::CMD_POP: begin
                if (head == NONE) begin
                  w_status <= sel_pkg::ST_EMPTY;
                  state    <= S_DONE;
                end else begin
                  w_status <= sel_pkg::ST_OK;
                  rem      <= head;
                  state    <= S_POP_DATA;
                end
              end
              sel_pkg::CMD_REMOVE: begin
                if (count == '0 || head == NONE) begin
                  w_status <= sel_pkg::ST_EMPTY;
                  state    <= S_DONE;
                end else if (cursor == NONE) begin
                  if (tail == NONE) begin
                    w_status <= sel_pkg::ST_EMPTY;
                    state    <= S_DONE;
                  end else begin
                    w_status <= sel_pkg::ST_OK;
                    rem      <= tail;
                    state    <= S_RMT_DATA;
                  end
                end else if (cursor == head) begin
                  w_status <= sel_pkg::ST_INVALID;
                  state    <= S_DONE;
                end else begin
                  w_status <= sel_pkg::ST_OK;
                  state    <= S_RMC_PRV;
                end
              end
              sel_pkg::CMD_CLEAR: begin
                free_head <= NONE;
                fill      <= '0;
                head      <= NONE;
                tail      <= NONE;
                cursor    <= NONE;
                count     <= '0;
                w_status  <= sel_pkg::ST_OK;
                state     <= S_DONE;
              end
              default: begin
                w_status <= sel_pkg::ST_OK;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_INS_FREE: begin
          free_head <= nxt_q;
          state     <= S_INS_WR;
        end
        S_INS_WR: begin
          rec_mem[n[AW-1:0]] <= rec_in;
          p     <= NONE;
          c     <= head;
          state <= S_WALK_RD;
        end
        S_WALK_RD: state <= (c == NONE) ? S_LINK1 : S_WALK_CMP;
        S_WALK_CMP: begin
          // equal keys: walk past, so arrival order holds
          if (walk_key <= key_new) begin
            p     <= c;
            c     <= nxt_q;
            state <= S_WALK_RD;
          end else begin
            state <= S_LINK1;
          end
        end
        S_LINK1: begin
          nxt_mem[n[AW-1:0]] <= c;
          prv_mem[n[AW-1:0]] <= p;
          state <= S_LINK2;
        end
        S_LINK2: begin
          if (p != NONE) nxt_mem[p[AW-1:0]] <= n;
          else head <= n;
          if (c != NONE) prv_mem[c[AW-1:0]] <= n;
          else tail <= n;
          count <= count + ONE;
          state <= S_DONE;
        end
        S_RD_DATA: begin
          w_rec  <= rec_q;
          cursor <= nxt_q;
          state  <= S_DONE;
        end
        S_POP_DATA: begin
          w_rec <= rec_q;
          if (nxt_q != NONE) begin
            prv_mem[nxt_q[AW-1:0]] <= NONE;
            head <= nxt_q;
          end else begin
            head <= NONE;
            tail <= NONE;
          end
          if (cursor == rem) cursor <= nxt_q;
          state <= S_REL;
        end
        S_RMT_DATA: begin
          w_rec <= rec_q;
          if (prv_q != NONE) begin
            nxt_mem[prv_q[AW-1:0]] <= NONE;
            tail <= prv_q;
          end else begin
            head <= NONE;
            tail <= NONE;
          end
          state <= S_REL;
        end
        S_RMC_PRV: begin
          rem <= prv_q;
          if (prv_q == NONE) begin
            w_status <= sel_pkg::ST_INVALID;
            state    <= S_DONE;
          end else begin
            state <= S_RMC_DATA;
          end
        end
        S_RMC_DATA: begin
          w_rec <= rec_q;
          prv_mem[cursor[AW-1:0]] <= prv_q;
          if (prv_q != NONE) nxt_mem[prv_q[AW-1:0]] <= cursor;
          else head <= cursor;
          state <= S_REL;
        end
        S_REL: begin
          // push the freed slot onto the released chain
          nxt_mem[rem[AW-1:0]] <= free_head;
          free_head <= rem;
          if (count != '0) count <= count - ONE;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid  <= 1'b1;
            res_status <= w_status;
            res_rec    <= w_rec;
            res_count  <= count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "sorted_event_list_assert.svh"

  `SEL_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= NONE && fill <= NONE)
  `SEL_ASSERT_IMPL(a_empty_list, clk, rst, count == '0, head == NONE && tail == NONE)
  `SEL_ASSERT_IMPL(a_held_list, clk, rst, state == S_IDLE && count != '0,
                   head != NONE && tail != NONE)
  `SEL_ASSERT_NEXT(a_full_insert, clk, rst,
                   cmd_fire && cmd.command == sel_pkg::CMD_INSERT && count == NONE,
                   state == S_DONE && w_status == sel_pkg::ST_FULL)

endmodule
`default_nettype wire

[tb/tb_sorted_event_list.sv]
`default_nettype none
module tb_sorted_event_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int NONE  = DEPTH;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pos;
    logic [31:0] dur;
    logic [31:0] rel;
    logic [31:0] pay;
    logic [6:0]  count;
  } result_t;

  typedef struct {
    logic [2:0]  command;
    logic [31:0] pos;
    logic [31:0] dur;
    logic [31:0] rel;
    logic [31:0] pay;
    bit          typed;
    result_t     want;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sel_cmd_if cmd_ch();
  sel_res_if #(.CW(7)) res_ch();
  sel_cfg_if cfg_ch();

  sorted_event_list u_dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch.sink), .res(res_ch.source), .cfg(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow list state
  logic [31:0] rec [DEPTH][4];
  int nxt [DEPTH];
  int prv [DEPTH];
  int free_hd, head, tail, cursor, held;
  logic [1:0] mode;

  result_t expected_results[$];
  int errors = 0;

  task automatic report(input string what, input string detail);
    errors++;
    $display("mismatch %s: %s", what, detail);
  endtask

  function automatic logic [31:0] key_at(int i);
    return (mode < 3) ? rec[i][mode] : 32'd0;
  endfunction

  task automatic list_reset();
    for (int i = 0; i < DEPTH; i++) begin
      nxt[i] = i + 1;
      prv[i] = NONE;
    end
    free_hd = 0; head = NONE; tail = NONE; cursor = NONE; held = 0;
  endtask

  function automatic result_t emit_rec(int i);
    result_t r;
    r = '0;
    r.pos = rec[i][0]; r.dur = rec[i][1]; r.rel = rec[i][2]; r.pay = rec[i][3];
    return r;
  endfunction

  task automatic free_slot(int i);
    nxt[i] = free_hd;
    free_hd = i;
    if (held > 0) held--;
  endtask

  task automatic predict_list(input stim_t s, output result_t r);
    int n, p, c, steps, h, rm;
    logic [31:0] k;
    r = '0;
    case (s.command)
      sel_pkg::CMD_INSERT: begin
        if (free_hd >= DEPTH) r.status = sel_pkg::ST_FULL;
        else begin
          n = free_hd;
          free_hd = nxt[n];
          rec[n][0] = s.pos; rec[n][1] = s.dur; rec[n][2] = s.rel; rec[n][3] = s.pay;
          k = key_at(n);
          p = NONE; c = head; steps = 0;
          while (c < DEPTH && steps < DEPTH && key_at(c) <= k) begin
            p = c; c = nxt[c]; steps++;
          end
          if (c >= DEPTH) c = NONE;
          nxt[n] = c; prv[n] = p;
          if (p < DEPTH) nxt[p] = n; else head = n;
          if (c < DEPTH) prv[c] = n; else tail = n;
          held++;
        end
      end
      sel_pkg::CMD_REWIND: cursor = head;
      sel_pkg::CMD_READ: begin
        if (held == 0 || head >= DEPTH) r.status = sel_pkg::ST_EMPTY;
        else if (cursor >= DEPTH) r.status = sel_pkg::ST_END;
        else begin
          r = emit_rec(cursor);
          cursor = nxt[cursor];
        end
      end
      sel_pkg::CMD_POP: begin
        h = head;
        if (h >= DEPTH) r.status = sel_pkg::ST_EMPTY;
        else begin
          r = emit_rec(h);
          head = nxt[h];
          if (head < DEPTH) prv[head] = NONE;
          else begin
            head = NONE; tail = NONE;
          end
          if (cursor == h) cursor = head;
          free_slot(h);
        end
      end
      sel_pkg::CMD_REMOVE: begin
        rm = NONE;
        if (held == 0 || head >= DEPTH) r.status = sel_pkg::ST_EMPTY;
        else if (cursor >= DEPTH) begin
          rm = tail;
          if (rm >= DEPTH) r.status = sel_pkg::ST_EMPTY;
          else begin
            p = prv[rm];
            if (p < DEPTH) begin
              nxt[p] = NONE; tail = p;
            end else begin
              head = NONE; tail = NONE;
            end
          end
        end else if (cursor == head || prv[cursor] >= DEPTH) r.status = sel_pkg::ST_INVALID;
        else begin
          rm = prv[cursor];
          p = prv[rm];
          prv[cursor] = (p < DEPTH) ? p : NONE;
          if (p < DEPTH) nxt[p] = cursor; else head = cursor;
        end
        if (r.status == sel_pkg::ST_OK && rm < DEPTH) begin
          r = emit_rec(rm);
          free_slot(rm);
        end
      end
      sel_pkg::CMD_CLEAR: list_reset();
      default: ;
    endcase
    r.count = held[6:0];
  endtask

  // response side: random stall pattern
  int stall_pct = 30;
  always @(negedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t got, exp;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.status, res_ch.out_position, res_ch.out_duration, res_ch.out_release,
              res_ch.out_payload, res_ch.entry_count};
      if (expected_results.size() == 0) report("unexpected beat", $sformatf("got %0h", got));
      else begin
        exp = expected_results.pop_front();
        if (got.status !== exp.status)
          report("status", $sformatf("got %0h expected %0h", got.status, exp.status));
        if (got.pos !== exp.pos)
          report("position", $sformatf("got %0h expected %0h", got.pos, exp.pos));
        if (got.dur !== exp.dur)
          report("duration", $sformatf("got %0h expected %0h", got.dur, exp.dur));
        if (got.rel !== exp.rel)
          report("release", $sformatf("got %0h expected %0h", got.rel, exp.rel));
        if (got.pay !== exp.pay)
          report("payload", $sformatf("got %0h expected %0h", got.pay, exp.pay));
        if (got.count !== exp.count)
          report("count", $sformatf("got %0h expected %0h", got.count, exp.count));
      end
    end
  end

  task automatic send_cmd(input stim_t s);
    result_t r;
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= s.command;
    cmd_ch.note_position <= s.pos;
    cmd_ch.note_duration <= s.dur;
    cmd_ch.release_time <= s.rel;
    cmd_ch.payload <= s.pay;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_list(s, r);
    if (s.typed && r !== s.want)
      report("directed row vs shadow", $sformatf("shadow %0h table %0h", r, s.want));
    expected_results.push_back(s.typed ? s.want : r);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.sort_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    mode = m;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic stim_t mk(logic [2:0] c, logic [31:0] p = 0, logic [31:0] d = 0,
                               logic [31:0] rl = 0, logic [31:0] py = 0);
    stim_t s;
    s.command = c; s.pos = p; s.dur = d; s.rel = rl; s.pay = py;
    s.typed = 0; s.want = '0;
    return s;
  endfunction

  function automatic stim_t mkw(logic [2:0] c, logic [2:0] st, logic [6:0] n);
    stim_t s;
    s = mk(c);
    s.typed = 1;
    s.want.status = st;
    s.want.count = n;
    return s;
  endfunction

  // keys often drawn from two narrow ranges so equal keys happen often
  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return 32'hFFFF_FFF8 + $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_t rand_cmd(int ins_pct);
    stim_t s;
    int pick;
    pick = $urandom_range(99);
    if (pick < ins_pct)
      s = mk(sel_pkg::CMD_INSERT, rand_key(), rand_key(), rand_key(), $urandom);
    else if (pick < ins_pct + 4) s = mk(sel_pkg::CMD_REWIND);
    else if (pick < 80) s = mk(sel_pkg::CMD_READ);
    else if (pick < 88) s = mk(sel_pkg::CMD_POP);
    else if (pick < 97) s = mk(sel_pkg::CMD_REMOVE);
    else if (pick < 99) s = mk(sel_pkg::CMD_CLEAR);
    else s = mk(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom);
    return s;
  endfunction

  stim_t table_rows[$];

  initial begin
    int sent, burst;
    list_reset();
    mode = sel_pkg::MODE_POS;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = sel_pkg::CMD_REWIND;
    cmd_ch.note_position = '0;
    cmd_ch.note_duration = '0;
    cmd_ch.release_time = '0;
    cmd_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.sort_mode = sel_pkg::MODE_POS;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    table_rows.push_back(mkw(sel_pkg::CMD_READ, sel_pkg::ST_EMPTY, 0));
    table_rows.push_back(mkw(sel_pkg::CMD_POP, sel_pkg::ST_EMPTY, 0));
    table_rows.push_back(mkw(sel_pkg::CMD_REMOVE, sel_pkg::ST_EMPTY, 0));
    table_rows.push_back(mkw(sel_pkg::CMD_REWIND, sel_pkg::ST_OK, 0));
    table_rows.push_back(mk(sel_pkg::CMD_INSERT, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                            32'hA5A5_5A5A));
    table_rows.push_back(mk(sel_pkg::CMD_INSERT, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
    table_rows.push_back(mk(sel_pkg::CMD_INSERT, 5, 5, 5, 1));
    table_rows.push_back(mk(sel_pkg::CMD_INSERT, 5, 7, 9, 2));
    table_rows.push_back(mkw(sel_pkg::CMD_REWIND, sel_pkg::ST_OK, 4));
    table_rows.push_back(mkw(sel_pkg::CMD_REMOVE, sel_pkg::ST_INVALID, 4));
    table_rows.push_back(mk(sel_pkg::CMD_READ));
    table_rows.push_back(mk(sel_pkg::CMD_READ));
    table_rows.push_back(mk(sel_pkg::CMD_REMOVE));
    table_rows.push_back(mk(sel_pkg::CMD_READ));
    table_rows.push_back(mk(sel_pkg::CMD_READ));
    table_rows.push_back(mk(sel_pkg::CMD_READ));
    table_rows.push_back(mk(sel_pkg::CMD_INSERT, 3, 3, 3, 3));
    table_rows.push_back(mk(sel_pkg::CMD_REMOVE));
    table_rows.push_back(mk(sel_pkg::CMD_REWIND));
    table_rows.push_back(mk(sel_pkg::CMD_POP));
    table_rows.push_back(mk(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    table_rows.push_back(mk(3'd7));
    table_rows.push_back(mkw(sel_pkg::CMD_CLEAR, sel_pkg::ST_OK, 0));
    table_rows.push_back(mkw(sel_pkg::CMD_READ, sel_pkg::ST_EMPTY, 0));
    foreach (table_rows[i]) send_cmd(table_rows[i]);
    @(negedge clk) cmd_ch.valid <= 1'b0;
    drain();

    // fill the pool to overflow under duration ordering
    write_mode(sel_pkg::MODE_DUR);
    for (int i = 0; i < DEPTH + 2; i++)
      send_cmd(mk(sel_pkg::CMD_INSERT, $urandom, rand_key(), $urandom, $urandom));
    @(negedge clk) cmd_ch.valid <= 1'b0;
    drain();

    // random phases over every sort mode, mode three included
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(2'(ph % 4));
      stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 70;
      for (int j = 0; j < 165; j += burst) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          send_cmd(rand_cmd((ph % 2) ? 45 : 30));
          sent++;
        end
        if ($urandom_range(3) != 0) begin
          @(negedge clk) cmd_ch.valid <= 1'b0;
          repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        if (j > 80 && j < 93) begin
          @(negedge clk) cmd_ch.valid <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk);
        end
      end
      @(negedge clk) cmd_ch.valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
